// File: sv/tcf_pkg.sv
package tcf_pkg;

  localparam int CordicSteps = 16;
  localparam int AtanLen     = 24;
  localparam int CordicIter  = (CordicSteps > AtanLen) ? AtanLen : CordicSteps;
  localparam int SqrtIter    = 24;
  localparam int CntW        = 5;
  localparam int VecW        = 44;
  localparam int AngW        = 28;
  localparam int PredW       = 34;
  localparam int MulBW       = 18;
  localparam int ProdW       = PredW + MulBW;
  localparam int SumW        = ProdW + 1;
  localparam int AngleLimit  = 23040;
  localparam int HalfTurn    = 180 * 65536;

  localparam logic [2:0] AddrBlend  = 3'd0;
  localparam logic [2:0] AddrPeriod = 3'd4;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
  } out_item_t;

  typedef struct packed {
    logic            load_in;
    logic            sq_y;
    logic            sq_z;
    logic            sqrt_step;
    logic            cor_init;
    logic            cor_step;
    logic            cor_last;
    logic            sel;
    logic            bl_gp;
    logic            bl_pred;
    logic            bl_w1;
    logic            bl_w2;
    logic            bl_fin;
    logic            out_load;
    logic [CntW-1:0] step;
  } tcf_cmd_t;

  function automatic logic [21:0] atan_deg(input logic [CntW-1:0] i);
    logic [21:0] v;
    case (i)
      5'd0:    v = 22'd2949120;
      5'd1:    v = 22'd1740967;
      5'd2:    v = 22'd919879;
      5'd3:    v = 22'd466945;
      5'd4:    v = 22'd234379;
      5'd5:    v = 22'd117304;
      5'd6:    v = 22'd58666;
      5'd7:    v = 22'd29335;
      5'd8:    v = 22'd14668;
      5'd9:    v = 22'd7334;
      5'd10:   v = 22'd3667;
      5'd11:   v = 22'd1833;
      5'd12:   v = 22'd917;
      5'd13:   v = 22'd458;
      5'd14:   v = 22'd229;
      5'd15:   v = 22'd115;
      5'd16:   v = 22'd57;
      5'd17:   v = 22'd29;
      5'd18:   v = 22'd14;
      5'd19:   v = 22'd7;
      5'd20:   v = 22'd4;
      5'd21:   v = 22'd2;
      5'd22:   v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

// File: sv/tcf_ctrl.sv
module tcf_ctrl import tcf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     out_ready,
  output logic     out_valid,
  output tcf_cmd_t cmd
);

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_SQY  = 11'b00000000010,
    S_SQZ  = 11'b00000000100,
    S_SQRT = 11'b00000001000,
    S_CINI = 11'b00000010000,
    S_CORD = 11'b00000100000,
    S_GP   = 11'b00001000000,
    S_PRED = 11'b00010000000,
    S_W1   = 11'b00100000000,
    S_W2   = 11'b01000000000,
    S_FIN  = 11'b10000000000
  } state_t;

  localparam logic [CntW-1:0] SqrtLast = CntW'(SqrtIter - 1);
  localparam logic [CntW-1:0] CordLast = CntW'(CordicIter - 1);

  state_t          state_r, state_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            sel_r, sel_nxt;
  logic            done_r, done_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && !done_r;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    sel_nxt       = sel_r;
    done_nxt      = done_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.sel       = sel_r;
    cmd.step      = cnt_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (done_r && slot_free) begin
      cmd.out_load  = 1'b1;
      out_valid_nxt = 1'b1;
      done_nxt      = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_SQY;
        end
      end
      S_SQY: begin
        cmd.sq_y  = 1'b1;
        state_nxt = S_SQZ;
      end
      S_SQZ: begin
        cmd.sq_z  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == SqrtLast) state_nxt = S_CINI;
      end
      S_CINI: begin
        cmd.cor_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_CORD;
      end
      S_CORD: begin
        cmd.cor_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CordLast) begin
          cmd.cor_last = 1'b1;
          sel_nxt      = !sel_r;
          state_nxt    = sel_r ? S_GP : S_CINI;
        end
      end
      S_GP: begin
        cmd.bl_gp = 1'b1;
        state_nxt = S_PRED;
      end
      S_PRED: begin
        cmd.bl_pred = 1'b1;
        state_nxt   = S_W1;
      end
      S_W1: begin
        cmd.bl_w1 = 1'b1;
        state_nxt = S_W2;
      end
      S_W2: begin
        cmd.bl_w2 = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.bl_fin = 1'b1;
        sel_nxt    = !sel_r;
        if (sel_r) begin
          done_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_GP;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      sel_r       <= 1'b0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      sel_r       <= sel_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: sv/tcf_dp.sv
module tcf_dp import tcf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  tcf_cmd_t    cmd,
  input  in_item_t    in_data,
  input  logic [16:0] weight,
  input  logic [15:0] period,
  output out_item_t   out_data
);

  in_item_t                  smp_r;
  logic        [31:0]        mag_r;
  logic        [47:0]        sr_r;
  logic        [26:0]        rem_r;
  logic        [23:0]        root_r;
  logic signed [VecW-1:0]    x_r, y_r;
  logic signed [AngW-1:0]    z_r;
  logic signed [AngW-1:0]    acc_roll_r, acc_pitch_r;
  logic signed [32:0]        gp_r;
  logic signed [PredW-1:0]   pred_r;
  logic signed [ProdW-1:0]   m1_r;
  logic signed [SumW-1:0]    sum_r;
  logic signed [15:0]        roll_est_r, pitch_est_r;
  out_item_t                 out_r;

  logic signed [PredW-1:0]   mul_a;
  logic signed [MulBW-1:0]   mul_b;
  logic signed [ProdW-1:0]   prod;
  logic signed [15:0]        est, gyro;
  logic signed [AngW-1:0]    acc;
  logic        [26:0]        rem_t, trial;
  logic signed [VecW-1:0]    xi, yi, dx, dy;
  logic signed [16:0]        nax;
  logic signed [23:0]        rnd;
  logic signed [AngW-1:0]    atan_s;

  assign est  = cmd.sel ? pitch_est_r : roll_est_r;
  assign gyro = cmd.sel ? smp_r.gyro_y : smp_r.gyro_x;
  assign acc  = cmd.sel ? acc_pitch_r : acc_roll_r;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd.sq_y) begin
      mul_a = PredW'(smp_r.accel_y);
      mul_b = MulBW'(smp_r.accel_y);
    end else if (cmd.sq_z) begin
      mul_a = PredW'(smp_r.accel_z);
      mul_b = MulBW'(smp_r.accel_z);
    end else if (cmd.bl_gp) begin
      mul_a = PredW'(gyro);
      mul_b = MulBW'({2'b00, period});
    end else if (cmd.bl_w1) begin
      mul_a = pred_r;
      mul_b = MulBW'(18'sd65536 - $signed({1'b0, weight}));
    end else if (cmd.bl_w2) begin
      mul_a = PredW'($signed({acc, 4'b0000}));
      mul_b = MulBW'({1'b0, weight});
    end
  end

  assign prod = mul_a * mul_b;

  assign rem_t = {rem_r[24:0], sr_r[47:46]};
  assign trial = {1'b0, root_r, 2'b01};

  assign nax = -(17'(smp_r.accel_x));
  always_comb begin
    if (cmd.sel) begin
      xi = VecW'({4'b0000, root_r, 16'h0000});
      yi = VecW'($signed({nax, 24'h000000}));
    end else begin
      xi = VecW'($signed({smp_r.accel_z, 16'h0000}));
      yi = VecW'($signed({smp_r.accel_y, 16'h0000}));
    end
  end

  assign dx     = y_r >>> cmd.step;
  assign dy     = x_r >>> cmd.step;
  assign atan_s = AngW'({1'b0, atan_deg(cmd.step)});
  assign rnd    = 24'((sum_r + SumW'(64'sd268435456)) >>> 29);

  logic signed [AngW-1:0] z_nxt;
  always_comb begin
    z_nxt = z_r;
    if (y_r > 0)      z_nxt = z_r + atan_s;
    else if (y_r < 0) z_nxt = z_r - atan_s;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) smp_r <= in_data;
    if (cmd.sq_y) mag_r <= prod[31:0];
    if (cmd.sq_z) begin
      sr_r   <= {mag_r + prod[31:0], 16'h0000};
      rem_r  <= '0;
      root_r <= '0;
    end
    if (cmd.sqrt_step) begin
      sr_r <= {sr_r[45:0], 2'b00};
      if (rem_t >= trial) begin
        rem_r  <= rem_t - trial;
        root_r <= {root_r[22:0], 1'b1};
      end else begin
        rem_r  <= rem_t;
        root_r <= {root_r[22:0], 1'b0};
      end
    end
    if (cmd.cor_init) begin
      if (xi < 0) begin
        x_r <= -xi;
        y_r <= -yi;
        z_r <= (yi >= 0) ? AngW'(HalfTurn) : -AngW'(HalfTurn);
      end else begin
        x_r <= xi;
        y_r <= yi;
        z_r <= '0;
      end
    end
    if (cmd.cor_step) begin
      z_r <= z_nxt;
      if (y_r > 0) begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
      end else if (y_r < 0) begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
      end
      if (cmd.cor_last) begin
        if (cmd.sel) acc_pitch_r <= z_nxt;
        else         acc_roll_r  <= z_nxt;
      end
    end
    if (cmd.bl_gp)   gp_r   <= prod[32:0];
    if (cmd.bl_pred) pred_r <= PredW'($signed({est, 13'h0000})) + PredW'(gp_r);
    if (cmd.bl_w1)   m1_r   <= prod;
    if (cmd.bl_w2)   sum_r  <= SumW'(m1_r) + SumW'(prod);
    if (cmd.out_load) begin
      out_r.roll_angle  <= roll_est_r;
      out_r.pitch_angle <= pitch_est_r;
      out_r.rate_x      <= smp_r.gyro_x;
      out_r.rate_y      <= smp_r.gyro_y;
      out_r.rate_z      <= smp_r.gyro_z;
    end
  end

  logic signed [15:0] sat;
  always_comb begin
    if (rnd > 24'sd23040)       sat = 16'(AngleLimit);
    else if (rnd < -24'sd23040) sat = -16'(AngleLimit);
    else                        sat = rnd[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      roll_est_r  <= '0;
      pitch_est_r <= '0;
    end else if (cmd.bl_fin) begin
      if (cmd.sel) pitch_est_r <= sat;
      else         roll_est_r  <= sat;
    end
  end

  assign out_data = out_r;

endmodule

// File: sv/tilt_complementary_filter_unit.sv
// Tilt complementary filter: roll and pitch from one IMU sample per transfer.
// Input channel (in_valid/in_ready/in_data) takes three accelerometer axes and
// three gyro rates; output channel (out_valid/out_ready/out_data) returns the
// blended roll and pitch in 1/128 degree and the gyro rates unchanged.
// One sample is processed at a time; in_ready is high only when the engine is
// idle and no finished result is waiting to enter the output register.
// The latency from the input transfer to out_valid is set by a 24-step
// square root, two 16-step CORDIC vectoring passes on one shared unit and two
// blends of GP, PRED, W1, W2 and FIN steps on one shared multiplier; a new
// sample can be taken in the cycle after the output register loads.
// The output register holds its result while out_ready is low; the engine
// takes the next sample meanwhile and waits at the end if the register is full.
// Reset clears both estimates to zero and loads blend weight 1311 and sample
// period 655. The APB port writes blend_weight at address 0 and sample_period
// at address 4; weights above 65536 act as 65536.
module tilt_complementary_filter_unit import tcf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  tcf_cmd_t    cmd;
  logic [16:0] blend_r;
  logic [15:0] period_r;
  logic [16:0] weight;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign weight = (blend_r > 17'd65536) ? 17'd65536 : blend_r;
  assign prdata = paddr[2] ? {16'h0000, period_r} : {15'h0000, blend_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blend_r  <= 17'd1311;
      period_r <= 16'd655;
    end else if (wr_en) begin
      if (paddr[2] == AddrPeriod[2]) period_r <= pwdata[15:0];
      else                           blend_r  <= pwdata[16:0];
    end
  end

  tcf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  tcf_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .weight   (weight),
    .period   (period_r),
    .out_data (out_data)
  );

  logic unused_addr;
  assign unused_addr = ^{paddr[1:0], AddrBlend, pwdata[31:17]};

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while engine busy");

  a_roll_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.roll_angle <= 16'sd23040 && out_data.roll_angle >= -16'sd23040))
    else $error("roll out of range");

  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.pitch_angle <= 16'sd23040 && out_data.pitch_angle >= -16'sd23040))
    else $error("pitch out of range");

endmodule
